### src/uwf_pkg.sv
`timescale 1ns / 1ps

package uwf_pkg;

  localparam int FIFO_DEPTH_DEF = 8;
  localparam int BYTE_W = 8;
  localparam int DIV_W = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int LVL_W = 3;
  localparam int CMP_W = 8;

  localparam logic [2:0] BIT_LAST = 3'd7;
  localparam logic [BYTE_W-1:0] LFSR_TAPS = 8'hB8;
  localparam logic [BYTE_W-1:0] LFSR_SEED = 8'h01;

  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_TX_WRITE = 2'd1,
    CMD_RX_READ  = 2'd2,
    CMD_FRAME    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_START = 3'd1,
    PH_DATA  = 3'd2,
    PH_STOP1 = 3'd3,
    PH_STOP2 = 3'd4
  } tx_phase_t;

  localparam logic [CFG_IDX_W-1:0] REG_BAUD_DIV   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXTRA_STOP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TX_WM_LVL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RX_WM_LVL  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TX_IRQ_EN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_RX_IRQ_EN  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_BIT_TRUE   = 3'd6;

endpackage

### src/uart_with_fifos_and_watermark_irq.sv
`timescale 1ns / 1ps

// pipeline: the result of an accepted item is registered in the s1 stage and then in the
// output register, from which it is offered
// throughput: one item per clock unless the output stalls; each fifo ram has one read and
// one write port and no item touches more than one access of each in a cycle
// reset: control, pointers, counts and watermarks cleared at once, line idle high,
// lfsr seeded; fifo ram contents are undefined until written, no clearing pass
module uart_with_fifos_and_watermark_irq #(
  parameter int FIFO_DEPTH = uwf_pkg::FIFO_DEPTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_cmd,
  input  logic [uwf_pkg::BYTE_W-1:0]      in_data_byte,
  input  logic                            in_frame_malformed,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_tx_line,
  output logic                            out_irq,
  output logic [uwf_pkg::BYTE_W-1:0]      out_read_data,
  output logic                            out_read_popped,
  output logic                            out_tx_full,
  output logic                            out_tx_pending,
  output logic                            out_rx_pending,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [uwf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [uwf_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import uwf_pkg::*;

  localparam int AW = $clog2(FIFO_DEPTH);
  localparam int CW = $clog2(FIFO_DEPTH + 1);
  localparam int SW = AW + 1;

  // configuration
  logic [DIV_W-1:0] div_r;
  logic             stop2_r;
  logic [LVL_W-1:0] txlvl_r;
  logic [LVL_W-1:0] rxlvl_r;
  logic             txen_r;
  logic             rxen_r;
  logic             btm_r;

  // state
  logic [AW-1:0]     tx_head_r, tx_head_nxt;
  logic [CW-1:0]     tx_cnt_r, tx_cnt_nxt;
  logic [AW-1:0]     rx_head_r, rx_head_nxt;
  logic [CW-1:0]     rx_cnt_r, rx_cnt_nxt;
  tx_phase_t         phase_r, phase_nxt;
  logic [2:0]        bit_r, bit_nxt;
  logic [DIV_W-1:0]  tick_r, tick_nxt;
  logic              line_r, line_nxt;
  logic              txwm_r, txwm_nxt;
  logic              rxwm_r, rxwm_nxt;
  logic [BYTE_W-1:0] lfsr_r, lfsr_nxt;
  logic [BYTE_W-1:0] shift_r;
  logic              tx_ld_r;

  // pipeline
  logic s1_v_r, s1_v_nxt;
  logic s1_line_r, s1_irq_r, s1_popped_r, s1_full_r, s1_txwm_r, s1_rxwm_r;
  logic out_valid_r, out_valid_nxt;
  logic out_line_r, out_irq_r, out_popped_r, out_full_r, out_txwm_r, out_rxwm_r;
  logic [BYTE_W-1:0] out_rdata_r;

  logic out_free, s1_adv, acc;
  cmd_t cmd;
  logic is_tick, tx_try, tx_pop, tx_step, tx_push, rx_pop, rx_push;
  logic tx_full, rx_full;
  logic [BYTE_W-1:0] shift_src;
  logic [SW-1:0] tx_sum, rx_sum;
  logic [AW-1:0] tx_tail, rx_tail;
  logic [BYTE_W-1:0] tx_rdata, rx_rdata, rx_wdata;
  logic irq_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r   <= '0;
      stop2_r <= 1'b0;
      txlvl_r <= '0;
      rxlvl_r <= '0;
      txen_r  <= 1'b0;
      rxen_r  <= 1'b0;
      btm_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BAUD_DIV:   div_r   <= cfg_data;
        REG_EXTRA_STOP: stop2_r <= cfg_data[0];
        REG_TX_WM_LVL:  txlvl_r <= cfg_data[LVL_W-1:0];
        REG_RX_WM_LVL:  rxlvl_r <= cfg_data[LVL_W-1:0];
        REG_TX_IRQ_EN:  txen_r  <= cfg_data[0];
        REG_RX_IRQ_EN:  rxen_r  <= cfg_data[0];
        REG_BIT_TRUE:   btm_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // handshake and pipeline flow
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_v_r && out_free;
  assign in_stall = s1_v_r && !out_free;
  assign acc      = in_valid && !in_stall;
  assign cmd      = cmd_t'(in_cmd);
  assign is_tick  = acc && (cmd == CMD_TICK);

  assign tx_full = (tx_cnt_r == CW'(FIFO_DEPTH));
  assign rx_full = (rx_cnt_r == CW'(FIFO_DEPTH));

  // pointer arithmetic
  assign tx_sum  = SW'(tx_head_r) + SW'(tx_cnt_r);
  assign rx_sum  = SW'(rx_head_r) + SW'(rx_cnt_r);
  assign tx_tail = (tx_sum >= SW'(FIFO_DEPTH)) ? AW'(tx_sum - SW'(FIFO_DEPTH)) : AW'(tx_sum);
  assign rx_tail = (rx_sum >= SW'(FIFO_DEPTH)) ? AW'(rx_sum - SW'(FIFO_DEPTH)) : AW'(rx_sum);

  // shift byte forwarded from the ram in the cycle after a pop
  assign shift_src = tx_ld_r ? tx_rdata : shift_r;

  // transmitter next state
  always_comb begin
    phase_nxt = phase_r;
    bit_nxt   = bit_r;
    tick_nxt  = tick_r;
    tx_try    = 1'b0;
    tx_pop    = 1'b0;
    tx_step   = 1'b0;
    if (is_tick) begin
      if (phase_r == PH_IDLE) begin
        tx_try  = 1'b1;
        tx_step = 1'b1;
      end else if (tick_r < div_r) begin
        tick_nxt = tick_r + 1'b1;
      end else begin
        tick_nxt = '0;
        tx_step  = 1'b1;
        case (phase_r)
          PH_START: begin
            phase_nxt = PH_DATA;
            bit_nxt   = '0;
          end
          PH_DATA: begin
            if (bit_r == BIT_LAST) begin
              phase_nxt = stop2_r ? PH_STOP1 : PH_STOP2;
            end else begin
              bit_nxt = bit_r + 1'b1;
            end
          end
          PH_STOP1: phase_nxt = PH_STOP2;
          default: begin
            phase_nxt = PH_IDLE;
            tx_try    = 1'b1;
          end
        endcase
      end
      if (tx_try) begin
        if (tx_cnt_r != '0) begin
          tx_pop    = 1'b1;
          phase_nxt = PH_START;
          bit_nxt   = '0;
          tick_nxt  = '0;
        end else begin
          phase_nxt = PH_IDLE;
        end
      end
    end
  end

  // line level
  always_comb begin
    line_nxt = line_r;
    if (tx_step) begin
      case (phase_nxt)
        PH_START: line_nxt = 1'b0;
        PH_DATA:  line_nxt = btm_r ? shift_src[BIT_LAST - bit_nxt] : 1'b0;
        default:  line_nxt = 1'b1;
      endcase
    end
  end

  // fifo bookkeeping and watermarks
  always_comb begin
    tx_push     = acc && (cmd == CMD_TX_WRITE) && !tx_full;
    rx_pop      = acc && (cmd == CMD_RX_READ) && (rx_cnt_r != '0);
    rx_push     = acc && (cmd == CMD_FRAME) && !rx_full;
    tx_head_nxt = tx_head_r;
    tx_cnt_nxt  = tx_cnt_r;
    rx_head_nxt = rx_head_r;
    rx_cnt_nxt  = rx_cnt_r;
    txwm_nxt    = txwm_r;
    rxwm_nxt    = rxwm_r;
    lfsr_nxt    = lfsr_r;
    rx_wdata    = in_data_byte;

    if (tx_pop) begin
      tx_head_nxt = (tx_head_r == AW'(FIFO_DEPTH - 1)) ? '0 : tx_head_r + 1'b1;
      tx_cnt_nxt  = tx_cnt_r - 1'b1;
    end else if (tx_push) begin
      tx_cnt_nxt = tx_cnt_r + 1'b1;
    end
    if (tx_pop || (acc && (cmd == CMD_TX_WRITE))) begin
      txwm_nxt = (tx_cnt_nxt != '0) && (CMP_W'(txlvl_r) <= CMP_W'(tx_cnt_nxt - 1'b1));
    end

    if (rx_pop) begin
      rx_head_nxt = (rx_head_r == AW'(FIFO_DEPTH - 1)) ? '0 : rx_head_r + 1'b1;
      rx_cnt_nxt  = rx_cnt_r - 1'b1;
    end else if (rx_push) begin
      rx_cnt_nxt = rx_cnt_r + 1'b1;
      if (in_frame_malformed) begin
        lfsr_nxt = (lfsr_r >> 1) ^ (lfsr_r[0] ? LFSR_TAPS : '0);
        rx_wdata = lfsr_nxt;
      end
    end
    if ((rx_pop || rx_push) && (CMP_W'(rxlvl_r) <= CMP_W'(rx_cnt_nxt))) begin
      rxwm_nxt = 1'b1;
    end
  end

  assign irq_nxt = (txwm_nxt & txen_r) | (rxwm_nxt & rxen_r);

  uwf_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (tx_push),
    .waddr (tx_tail),
    .wdata (in_data_byte),
    .re    (tx_pop),
    .raddr (tx_head_r),
    .rdata (tx_rdata)
  );

  uwf_ram #(.WIDTH(BYTE_W), .DEPTH(FIFO_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (rx_push),
    .waddr (rx_tail),
    .wdata (rx_wdata),
    .re    (rx_pop),
    .raddr (rx_head_r),
    .rdata (rx_rdata)
  );

  assign s1_v_nxt      = acc ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
  assign out_valid_nxt = s1_adv ? 1'b1 : (out_free ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_head_r   <= '0;
      tx_cnt_r    <= '0;
      rx_head_r   <= '0;
      rx_cnt_r    <= '0;
      phase_r     <= PH_IDLE;
      bit_r       <= '0;
      tick_r      <= '0;
      line_r      <= 1'b1;
      txwm_r      <= 1'b0;
      rxwm_r      <= 1'b0;
      lfsr_r      <= LFSR_SEED;
      shift_r     <= '0;
      tx_ld_r     <= 1'b0;
      s1_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
      out_rdata_r <= '0;
    end else begin
      tx_head_r   <= tx_head_nxt;
      tx_cnt_r    <= tx_cnt_nxt;
      rx_head_r   <= rx_head_nxt;
      rx_cnt_r    <= rx_cnt_nxt;
      phase_r     <= phase_nxt;
      bit_r       <= bit_nxt;
      tick_r      <= tick_nxt;
      line_r      <= line_nxt;
      txwm_r      <= txwm_nxt;
      rxwm_r      <= rxwm_nxt;
      lfsr_r      <= lfsr_nxt;
      shift_r     <= shift_src;
      tx_ld_r     <= tx_pop;
      s1_v_r      <= s1_v_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_adv && s1_popped_r) begin
        out_rdata_r <= rx_rdata;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_line_r   <= line_nxt;
      s1_irq_r    <= irq_nxt;
      s1_popped_r <= rx_pop;
      s1_full_r   <= (tx_cnt_nxt == CW'(FIFO_DEPTH));
      s1_txwm_r   <= txwm_nxt;
      s1_rxwm_r   <= rxwm_nxt;
    end
    if (s1_adv) begin
      out_line_r   <= s1_line_r;
      out_irq_r    <= s1_irq_r;
      out_popped_r <= s1_popped_r;
      out_full_r   <= s1_full_r;
      out_txwm_r   <= s1_txwm_r;
      out_rxwm_r   <= s1_rxwm_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_tx_line     = out_line_r;
  assign out_irq         = out_irq_r;
  assign out_read_data   = out_rdata_r;
  assign out_read_popped = out_popped_r;
  assign out_tx_full     = out_full_r;
  assign out_tx_pending  = out_txwm_r;
  assign out_rx_pending  = out_rxwm_r;

endmodule

### src/uwf_ram.sv
`timescale 1ns / 1ps

module uwf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
